>>> rtl/c8_pkg.sv
`default_nettype none
package c8_pkg;

  localparam int ADDR_W      = 12;
  localparam int MEM_BYTES   = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int COL_W       = $clog2(SCREEN_W);
  localparam int ROW_W       = $clog2(SCREEN_H);
  localparam int PIXELS      = SCREEN_W * SCREEN_H;
  localparam logic [ADDR_W-1:0] RESET_PC = 12'h200;

  // Request commands
  typedef enum logic [2:0] {
    CMD_EXEC  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_PIXEL = 3'd4
  } c8_cmd_t;

  // Shared arithmetic unit operations
  typedef enum logic [2:0] {
    ALU_ADD  = 3'd0,
    ALU_SUB  = 3'd1,
    ALU_AND  = 3'd2,
    ALU_OR   = 3'd3,
    ALU_XOR  = 3'd4,
    ALU_SHR  = 3'd5,
    ALU_SHL  = 3'd6,
    ALU_PASS = 3'd7
  } c8_alu_op_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [ADDR_W-1:0] address;
    logic [7:0]        write_data;
    logic [15:0]       keys_down;
    logic [7:0]        random_byte;
  } c8_req_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic [ADDR_W-1:0] program_counter;
    logic              draw_flag;
    logic              waiting_for_key;
    logic              sound_on;
    logic              bad_opcode;
  } c8_res_t;

endpackage
`default_nettype wire

>>> rtl/c8_if.sv
`default_nettype none
interface c8_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                command;
  logic [c8_pkg::ADDR_W-1:0] address;
  logic [7:0]                write_data;
  logic [15:0]               keys_down;
  logic [7:0]                random_byte;

  modport source (output valid, command, address, write_data, keys_down, random_byte,
                  input ready);
  modport sink (input valid, command, address, write_data, keys_down, random_byte,
                output ready);
endinterface

interface c8_out_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                read_data;
  logic [c8_pkg::ADDR_W-1:0] program_counter;
  logic                      draw_flag;
  logic                      waiting_for_key;
  logic                      sound_on;
  logic                      bad_opcode;

  modport source (output valid, read_data, program_counter, draw_flag, waiting_for_key,
                  sound_on, bad_opcode, input ready);
  modport sink (input valid, read_data, program_counter, draw_flag, waiting_for_key,
                sound_on, bad_opcode, output ready);
endinterface
`default_nettype wire

>>> rtl/c8_alu.sv
`default_nettype none
module c8_alu (
  input  c8_pkg::c8_alu_op_t op,
  input  logic [11:0]        a,
  input  logic [11:0]        b,
  output logic [12:0]        y
);
  import c8_pkg::*;

  // Bit 12 is carry out for add and borrow for subtract
  always_comb begin
    unique case (op)
      ALU_ADD:  y = {1'b0, a} + {1'b0, b};
      ALU_SUB:  y = {1'b0, a} - {1'b0, b};
      ALU_AND:  y = {1'b0, a & b};
      ALU_OR:   y = {1'b0, a | b};
      ALU_XOR:  y = {1'b0, a ^ b};
      ALU_SHR:  y = {2'b0, a[11:1]};
      ALU_SHL:  y = {a, 1'b0};
      ALU_PASS: y = {1'b0, b};
      default:  y = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/c8_core.sv
`default_nettype none
module c8_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  c8_pkg::c8_req_t req,
  output logic            req_ready,
  output logic            res_valid,
  output c8_pkg::c8_res_t res,
  input  logic            res_take
);
  import c8_pkg::*;

  // Opcode groups
  localparam logic [3:0] OP_SYS = 4'h0, OP_JP = 4'h1, OP_CALL = 4'h2, OP_SEK = 4'h3;
  localparam logic [3:0] OP_SNEK = 4'h4, OP_SEV = 4'h5, OP_LDK = 4'h6, OP_ADDK = 4'h7;
  localparam logic [3:0] OP_ALU = 4'h8, OP_SNEV = 4'h9, OP_LDI = 4'hA, OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND = 4'hC, OP_DRW = 4'hD, OP_SKP = 4'hE, OP_MISC = 4'hF;
  // Register-register operations
  localparam logic [3:0] A_MOV = 4'h0, A_OR = 4'h1, A_AND = 4'h2, A_XOR = 4'h3;
  localparam logic [3:0] A_ADD = 4'h4, A_SUB = 4'h5, A_SHR = 4'h6, A_SUBN = 4'h7;
  localparam logic [3:0] A_SHL = 4'hE;
  // Low-byte sub-codes
  localparam logic [7:0] K_CLS = 8'hE0, K_RET = 8'hEE, K_SKP = 8'h9E, K_SKNP = 8'hA1;
  localparam logic [7:0] K_LDVDT = 8'h07, K_WAITK = 8'h0A, K_LDDT = 8'h15;
  localparam logic [7:0] K_LDST = 8'h18, K_ADDI = 8'h1E, K_LDF = 8'h29, K_BCD = 8'h33;
  localparam logic [7:0] K_STM = 8'h55, K_LDM = 8'h65;
  localparam logic [3:0] REG_F = 4'hF;

  typedef enum logic [22:0] {
    S_CLEAR  = 23'h000001,
    S_IDLE   = 23'h000002,
    S_RDWAIT = 23'h000004,
    S_F1     = 23'h000008,
    S_F2     = 23'h000010,
    S_F3     = 23'h000020,
    S_F4     = 23'h000040,
    S_F5     = 23'h000080,
    S_EXEC   = 23'h000100,
    S_FLAG   = 23'h000200,
    S_RET    = 23'h000400,
    S_CLS    = 23'h000800,
    S_D_RD   = 23'h001000,
    S_D_WR   = 23'h002000,
    S_D_END  = 23'h004000,
    S_BCD    = 23'h008000,
    S_ST_RD  = 23'h010000,
    S_ST_WR  = 23'h020000,
    S_LD_RD  = 23'h040000,
    S_LD_WR  = 23'h080000,
    S_IUPD   = 23'h100000,
    S_PC     = 23'h200000,
    S_DONE   = 23'h400000
  } state_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = v[7-k];
    return r;
  endfunction

  function automatic logic [3:0] key_high(input logic [15:0] keys);
    logic [3:0] r;
    r = '0;
    for (int k = 0; k < 16; k++) if (keys[k]) r = 4'(k);
    return r;
  endfunction

  state_t            state;
  logic [11:0]       cnt;
  logic [3:0]        idx;
  c8_req_t           req_q;
  logic [7:0]        op_hi, op_lo, va, vb;
  logic [ADDR_W-1:0] pc, ireg;
  logic [7:0]        dt, st, rd;
  logic [SP_W-1:0]   sp;
  logic              flag, coll, draw, wait_k, bad;
  logic [ROW_W-1:0]  d_row;
  logic [2:0]        step;

  // Storage
  logic [7:0]          ram [0:MEM_BYTES-1];
  logic [7:0]          ram_q;
  logic [7:0]          vreg [0:15];
  logic [7:0]          vq;
  logic [SCREEN_W-1:0] fb [0:SCREEN_H-1];
  logic [SCREEN_W-1:0] fb_q;
  logic [11:0]         stk [0:STACK_DEPTH-1];
  logic [11:0]         s_q;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_wa, ram_ra;
  logic [7:0]          ram_wd;
  logic                v_we;
  logic [3:0]          v_wa, v_ra;
  logic [7:0]          v_wd;
  logic                fb_we;
  logic [ROW_W-1:0]    fb_wa, fb_ra;
  logic [SCREEN_W-1:0] fb_wd;
  logic                stk_we;

  c8_alu_op_t  alu_op;
  logic [11:0] alu_a, alu_b;
  logic [12:0] alu_y;

  // Instruction fields and helpers
  logic [3:0]          grp, rx, ry, nib;
  logic [7:0]          kk, a_f, b_f, hund, tens, ones, rnd_m, digit;
  logic [6:0]          rem;
  logic [14:0]         tprod;
  logic [11:0]         nnn;
  logic                key_t, y_zero;
  logic [SP_W-1:0]     sp_inc, sp_dec;
  logic [2*SCREEN_W-1:0] mask_w;
  logic [SCREEN_W-1:0] mask;

  assign grp = op_hi[7:4];
  assign rx  = op_hi[3:0];
  assign ry  = op_lo[7:4];
  assign nib = op_lo[3:0];
  assign kk  = op_lo;
  assign nnn = {op_hi[3:0], op_lo};
  assign a_f = (rx == REG_F) ? {7'b0, flag} : va;
  assign b_f = (ry == REG_F) ? {7'b0, flag} : vb;
  assign key_t  = (va[7:4] == 4'd0) ? req_q.keys_down[va[3:0]] : 1'b0;
  assign y_zero = (alu_y[11:0] == 12'd0);
  assign rnd_m  = (req_q.random_byte == 8'hFF) ? 8'd0 : req_q.random_byte;
  assign sp_inc = (sp == SP_W'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;
  assign sp_dec = (sp == '0) ? SP_W'(STACK_DEPTH - 1) : sp - 1'b1;

  // Decimal digits of Vx: compare for hundreds, reciprocal multiply for tens
  always_comb begin
    if (va >= 8'd200) begin
      hund = 8'd2;
      rem  = 7'(va - 8'd200);
    end else if (va >= 8'd100) begin
      hund = 8'd1;
      rem  = 7'(va - 8'd100);
    end else begin
      hund = 8'd0;
      rem  = va[6:0];
    end
    tprod = 15'(rem) * 15'd205;
    tens  = {4'b0, tprod[14:11]};
    ones  = 8'(rem) - 8'(tens * 8'd10);
    case (idx[1:0])
      2'd0:    digit = hund;
      2'd1:    digit = tens;
      default: digit = ones;
    endcase
  end

  // Sprite row placed at column Vx with wrap-around
  assign mask_w = {{(2*SCREEN_W-8){1'b0}}, rev8(ram_q)} << va[COL_W-1:0];
  assign mask   = mask_w[SCREEN_W-1:0] | mask_w[2*SCREEN_W-1:SCREEN_W];

  c8_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

  // Memory ports and shared unit operands per state
  always_comb begin
    ram_we = 1'b0; ram_wa = '0; ram_wd = '0; ram_ra = '0;
    v_we = 1'b0; v_wa = '0; v_wd = '0; v_ra = '0;
    fb_we = 1'b0; fb_wa = '0; fb_wd = '0; fb_ra = '0;
    stk_we = 1'b0;
    alu_op = ALU_ADD; alu_a = pc; alu_b = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1; ram_wa = cnt;
        fb_we = 1'b1; fb_wa = cnt[ROW_W-1:0];
        v_we = 1'b1; v_wa = cnt[3:0];
      end
      S_IDLE: begin
        ram_we = req_valid && (req.command == CMD_WRITE);
        ram_wa = req.address;
        ram_wd = req.write_data;
        ram_ra = req.address;
        fb_ra  = req.address[ROW_W+COL_W-1:COL_W];
      end
      S_F1: ram_ra = pc;
      S_F2: begin
        alu_b  = 12'd1;
        ram_ra = alu_y[11:0];
      end
      S_F3: v_ra = op_hi[3:0];
      S_F4: v_ra = (grp == OP_JPV0) ? 4'd0 : op_lo[7:4];
      S_EXEC: begin
        unique case (grp)
          OP_CALL: stk_we = 1'b1;
          OP_SEK, OP_SNEK: begin
            alu_op = ALU_SUB; alu_a = {4'b0, va}; alu_b = {4'b0, kk};
          end
          OP_SEV, OP_SNEV: begin
            alu_op = ALU_SUB; alu_a = {4'b0, va}; alu_b = {4'b0, vb};
          end
          OP_LDK: begin
            v_we = 1'b1; v_wa = rx; v_wd = kk;
          end
          OP_ADDK: begin
            alu_a = {4'b0, va}; alu_b = {4'b0, kk};
            v_we = 1'b1; v_wa = rx; v_wd = alu_y[7:0];
          end
          OP_ALU: begin
            alu_a = {4'b0, va}; alu_b = {4'b0, vb};
            unique case (nib)
              A_MOV, A_OR, A_AND, A_XOR, A_ADD: begin
                v_we = 1'b1; v_wa = rx; v_wd = alu_y[7:0];
                case (nib)
                  A_MOV:   alu_op = ALU_PASS;
                  A_OR:    alu_op = ALU_OR;
                  A_AND:   alu_op = ALU_AND;
                  A_XOR:   alu_op = ALU_XOR;
                  default: alu_op = ALU_ADD;
                endcase
              end
              A_SUB: begin
                alu_op = ALU_SUB; alu_a = {4'b0, vb}; alu_b = {4'b0, va};
                v_we = 1'b1; v_wa = REG_F; v_wd = {7'b0, alu_y[12]};
              end
              A_SUBN: begin
                alu_op = ALU_SUB;
                v_we = 1'b1; v_wa = REG_F; v_wd = {7'b0, alu_y[12]};
              end
              A_SHR: begin
                v_we = 1'b1; v_wa = REG_F; v_wd = {7'b0, va[0]};
              end
              A_SHL: begin
                v_we = 1'b1; v_wa = REG_F; v_wd = {7'b0, va[7]};
              end
              default: ;
            endcase
          end
          OP_JPV0: begin
            alu_a = {4'b0, vb}; alu_b = nnn;
          end
          OP_RND: begin
            v_we = 1'b1; v_wa = rx; v_wd = rnd_m & kk;
          end
          OP_MISC: begin
            unique case (kk)
              K_LDVDT: begin
                v_we = 1'b1; v_wa = rx; v_wd = dt;
              end
              K_WAITK: begin
                v_we = (req_q.keys_down != 16'd0); v_wa = rx;
                v_wd = {4'b0, key_high(req_q.keys_down)};
              end
              K_ADDI: begin
                alu_a = ireg; alu_b = {4'b0, va};
                v_we = 1'b1; v_wa = REG_F; v_wd = {7'b0, alu_y[12]};
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_FLAG: begin
        if (grp == OP_ALU && nib == A_ADD) begin
          v_we = 1'b1; v_wa = REG_F; v_wd = {7'b0, flag};
        end else if (grp == OP_ALU) begin
          v_we = 1'b1; v_wa = rx; v_wd = alu_y[7:0];
          alu_a = {4'b0, a_f}; alu_b = {4'b0, b_f};
          case (nib)
            A_SUB:   alu_op = ALU_SUB;
            A_SUBN: begin
              alu_op = ALU_SUB; alu_a = {4'b0, b_f}; alu_b = {4'b0, a_f};
            end
            A_SHR:   alu_op = ALU_SHR;
            default: alu_op = ALU_SHL;
          endcase
        end else begin
          alu_a = ireg; alu_b = {4'b0, a_f};
        end
      end
      S_CLS: begin
        fb_we = 1'b1; fb_wa = cnt[ROW_W-1:0];
      end
      S_D_RD: begin
        alu_a  = ireg; alu_b = {8'b0, idx};
        ram_ra = alu_y[11:0];
        fb_ra  = ROW_W'(vb[ROW_W-1:0] + ROW_W'(idx));
      end
      S_D_WR: begin
        fb_we = 1'b1; fb_wa = d_row; fb_wd = fb_q ^ mask;
      end
      S_D_END: begin
        v_we = 1'b1; v_wa = REG_F; v_wd = {7'b0, coll};
      end
      S_BCD: begin
        alu_a  = ireg; alu_b = {8'b0, idx};
        ram_we = 1'b1; ram_wa = alu_y[11:0]; ram_wd = digit;
      end
      S_ST_RD: v_ra = idx;
      S_ST_WR: begin
        alu_a  = ireg; alu_b = {8'b0, idx};
        ram_we = 1'b1; ram_wa = alu_y[11:0]; ram_wd = vq;
      end
      S_LD_RD: begin
        alu_a  = ireg; alu_b = {8'b0, idx};
        ram_ra = alu_y[11:0];
      end
      S_LD_WR: begin
        v_we = 1'b1; v_wa = idx; v_wd = ram_q;
      end
      S_IUPD: begin
        alu_a = ireg; alu_b = 12'({1'b0, rx} + 5'd1);
      end
      S_PC: alu_b = {9'b0, step};
      default: ;
    endcase
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (ram_we) ram[ram_wa] <= ram_wd;
    ram_q <= ram[ram_ra];
  end

  always_ff @(posedge clk) begin
    if (v_we) vreg[v_wa] <= v_wd;
    vq <= vreg[v_ra];
  end

  always_ff @(posedge clk) begin
    if (fb_we) fb[fb_wa] <= fb_wd;
    fb_q <= fb[fb_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk[sp_inc] <= pc;
    s_q <= stk[sp];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      pc    <= RESET_PC;
      ireg  <= '0;
      dt    <= '0;
      st    <= '0;
      sp    <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == 12'(MEM_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            req_q  <= req;
            rd     <= '0;
            draw   <= 1'b0;
            wait_k <= 1'b0;
            bad    <= 1'b0;
            case (req.command)
              CMD_EXEC:  state <= S_F1;
              CMD_TICK: begin
                if (dt != 8'd0) dt <= dt - 1'b1;
                if (st != 8'd0) st <= st - 1'b1;
                state <= S_DONE;
              end
              CMD_READ, CMD_PIXEL: state <= S_RDWAIT;
              default:   state <= S_DONE;
            endcase
          end
        end
        S_RDWAIT: begin
          if (req_q.command == CMD_READ) begin
            rd <= ram_q;
          end else begin
            rd <= {7'b0, (req_q.address < 12'(PIXELS)) & fb_q[req_q.address[COL_W-1:0]]};
          end
          state <= S_DONE;
        end
        S_F1: state <= S_F2;
        S_F2: begin
          op_hi <= ram_q;
          state <= S_F3;
        end
        S_F3: begin
          op_lo <= ram_q;
          state <= S_F4;
        end
        S_F4: begin
          va    <= vq;
          state <= S_F5;
        end
        S_F5: begin
          vb    <= vq;
          state <= S_EXEC;
        end
        S_EXEC: begin
          step  <= 3'd2;
          state <= S_PC;
          unique case (grp)
            OP_SYS: begin
              if (kk == K_CLS) begin
                draw  <= 1'b1;
                cnt   <= '0;
                state <= S_CLS;
              end else if (kk == K_RET) begin
                state <= S_RET;
              end else begin
                bad  <= 1'b1;
                step <= 3'd1;
              end
            end
            OP_JP: begin
              pc   <= nnn;
              step <= 3'd0;
            end
            OP_CALL: begin
              sp   <= sp_inc;
              pc   <= nnn;
              step <= 3'd0;
            end
            OP_SEK, OP_SEV:   step <= y_zero ? 3'd4 : 3'd2;
            OP_SNEK, OP_SNEV: step <= y_zero ? 3'd2 : 3'd4;
            OP_LDK, OP_ADDK, OP_RND: ;
            OP_ALU: begin
              unique case (nib)
                A_MOV, A_OR, A_AND, A_XOR: ;
                A_ADD: begin
                  flag  <= alu_y[8];
                  state <= S_FLAG;
                end
                A_SUB, A_SUBN: begin
                  flag  <= alu_y[12];
                  state <= S_FLAG;
                end
                A_SHR: begin
                  flag  <= va[0];
                  state <= S_FLAG;
                end
                A_SHL: begin
                  flag  <= va[7];
                  state <= S_FLAG;
                end
                default: begin
                  bad  <= 1'b1;
                  step <= 3'd1;
                end
              endcase
            end
            OP_LDI: ireg <= nnn;
            OP_JPV0: begin
              pc   <= alu_y[11:0];
              step <= 3'd0;
            end
            OP_DRW: begin
              draw  <= 1'b1;
              idx   <= '0;
              coll  <= 1'b0;
              state <= (nib == 4'd0) ? S_D_END : S_D_RD;
            end
            OP_SKP: begin
              if (kk == K_SKP) begin
                step <= key_t ? 3'd4 : 3'd2;
              end else if (kk == K_SKNP) begin
                step <= key_t ? 3'd2 : 3'd4;
              end else begin
                bad  <= 1'b1;
                step <= 3'd1;
              end
            end
            OP_MISC: begin
              unique case (kk)
                K_LDVDT: ;
                K_WAITK: begin
                  if (req_q.keys_down == 16'd0) begin
                    wait_k <= 1'b1;
                    step   <= 3'd0;
                  end
                end
                K_LDDT: dt <= va;
                K_LDST: st <= va;
                K_ADDI: begin
                  flag  <= alu_y[12];
                  state <= S_FLAG;
                end
                K_LDF: ireg <= {2'b0, va, 2'b0} + {4'b0, va};
                K_BCD: begin
                  idx   <= '0;
                  state <= S_BCD;
                end
                K_STM: begin
                  idx   <= '0;
                  state <= S_ST_RD;
                end
                K_LDM: begin
                  idx   <= '0;
                  state <= S_LD_RD;
                end
                default: begin
                  bad  <= 1'b1;
                  step <= 3'd1;
                end
              endcase
            end
            default: ;
          endcase
        end
        S_FLAG: begin
          if (grp == OP_MISC) ireg <= alu_y[11:0];
          state <= S_PC;
        end
        S_RET: begin
          pc    <= s_q;
          sp    <= sp_dec;
          state <= S_PC;
        end
        S_CLS: begin
          cnt <= cnt + 1'b1;
          if (cnt[ROW_W-1:0] == ROW_W'(SCREEN_H - 1)) state <= S_PC;
        end
        S_D_RD: begin
          d_row <= fb_ra;
          state <= S_D_WR;
        end
        S_D_WR: begin
          coll <= coll | (|(fb_q & mask));
          idx  <= idx + 1'b1;
          state <= (idx == nib - 4'd1) ? S_D_END : S_D_RD;
        end
        S_D_END: state <= S_PC;
        S_BCD: begin
          idx <= idx + 1'b1;
          if (idx == 4'd2) state <= S_PC;
        end
        S_ST_RD: state <= S_ST_WR;
        S_ST_WR: begin
          idx   <= idx + 1'b1;
          state <= (idx == rx) ? S_IUPD : S_ST_RD;
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: begin
          idx   <= idx + 1'b1;
          state <= (idx == rx) ? S_IUPD : S_LD_RD;
        end
        S_IUPD: begin
          ireg  <= alu_y[11:0];
          state <= S_PC;
        end
        S_PC: begin
          pc    <= alu_y[11:0];
          state <= S_DONE;
        end
        S_DONE: if (res_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res = '{read_data: rd, program_counter: pc, draw_flag: draw,
                 waiting_for_key: wait_k, sound_on: (st != 8'd0), bad_opcode: bad};
endmodule
`default_nettype wire

>>> rtl/chip8_instruction_core_unit.sv
`default_nettype none
// Channel  Dir  Payload
// in_ch    in   command, address, write_data, keys_down, random_byte
// out_ch   out  read_data, program_counter, draw_flag, waiting_for_key, sound_on, bad_opcode
//
// One request at a time. RAM write, tick and spare commands go straight to the result;
// reads wait for the registered read. A plain instruction: fetch, two register reads,
// execute, PC update, hand-over; CLS adds a pass over the screen rows, DRW a read and write
// per sprite row and a VF write, BCD a write per digit, ALU flag ops, ADD I and RET a state
// each, block moves a read and write per register and an I update. After reset a clearing
// pass zeroes RAM, registers and screen. A stalled result does not block the next request.
module chip8_instruction_core_unit (
  input logic   clk,
  input logic   rst,
  c8_in_if.sink  in_ch,
  c8_out_if.source out_ch
);
  import c8_pkg::*;

  c8_req_t req;
  c8_res_t res, out_q;
  logic    req_ready, res_valid, res_take, out_valid;

  assign req = '{command: in_ch.command, address: in_ch.address,
                 write_data: in_ch.write_data, keys_down: in_ch.keys_down,
                 random_byte: in_ch.random_byte};

  c8_core u_core (
    .clk      (clk),
    .rst      (rst),
    .req_valid(in_ch.valid),
    .req      (req),
    .req_ready(req_ready),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  assign in_ch.ready = req_ready;

  // Output register: load when empty or being drained
  assign res_take = res_valid && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_q <= res;
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.read_data       = out_q.read_data;
  assign out_ch.program_counter = out_q.program_counter;
  assign out_ch.draw_flag       = out_q.draw_flag;
  assign out_ch.waiting_for_key = out_q.waiting_for_key;
  assign out_ch.sound_on        = out_q.sound_on;
  assign out_ch.bad_opcode      = out_q.bad_opcode;
endmodule
`default_nettype wire

>>> rtl/c8_checker.sv
`default_nettype none
module c8_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  read_data,
  input logic [11:0] program_counter,
  input logic        draw_flag,
  input logic        waiting_for_key,
  input logic        bad_opcode
);

  // A taken request closes the input until its work is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after a request was taken");

  // Clearing pass holds the input closed after reset
  a_closed_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input ready during clearing pass");

  // At most one instruction flag per result
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({draw_flag, waiting_for_key, bad_opcode}) <= 1)
    else $error("conflicting instruction flags");

  // Read data only comes with non-execute results
  a_read_no_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_data != 8'd0 |-> !draw_flag && !waiting_for_key && !bad_opcode)
    else $error("read data alongside execute flags");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(program_counter))
    else $error("stalled result changed");
endmodule

bind chip8_instruction_core_unit c8_checker u_c8_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .read_data      (out_ch.read_data),
  .program_counter(out_ch.program_counter),
  .draw_flag      (out_ch.draw_flag),
  .waiting_for_key(out_ch.waiting_for_key),
  .bad_opcode     (out_ch.bad_opcode)
);
`default_nettype wire
